>>> design/lgu_pkg.sv
// lgu_pkg: shared constants for the loss gradient unit.
// Loss mode codes, configuration register indexes and default widths.
// No dependencies.
package lgu_pkg;

    localparam int DefFracBits = 16;
    localparam int CfgDataW    = 31;
    localparam int CfgIndexW   = 2;

    typedef enum logic [1:0] {
        MODE_MSE   = 2'd0,
        MODE_CCE   = 2'd1,
        MODE_BCE   = 2'd2,
        MODE_HUBER = 2'd3
    } loss_mode_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_LOSS_MODE     = 2'd0,
        REG_ELEMENT_COUNT = 2'd1,
        REG_BATCH_COUNT   = 2'd2,
        REG_HUBER_DELTA   = 2'd3
    } cfg_index_t;

endpackage

>>> design/loss_gradient_unit_top.sv
// loss_gradient_unit_top: pipelined loss gradient element unit.
// Front end builds numerator and denominator, then one restoring divider stage per quotient bit.
// Depends on lgu_pkg.
//
// One item is accepted in every cycle (busy is always low). Its result passes the front-end stages,
// the divider load register, one divider stage per quotient bit and the output register to done.
// Results cannot be held off, so the receiver must take every done cycle. Configuration must be
// written only while no item is in flight; the block itself does not enforce this.
module loss_gradient_unit_top #(
    parameter int FRAC_BITS = lgu_pkg::DefFracBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            pred_value,
    input  logic signed [31:0]            target_value,
    input  logic                          cfg_write,
    input  logic [lgu_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [lgu_pkg::CfgDataW-1:0]  cfg_data,
    output logic                          done,
    output logic signed [31:0]            grad_value,
    output logic                          saturated
);
    import lgu_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int DW  = 2*F + 24;
    localparam int NW  = 2*F + 33;
    localparam int LAT = NW + 5;
    localparam longint One  = 64'(1) << F;
    localparam longint BLo  = (One + 9999) / 10000;
    localparam longint BHi  = (One * 9999) / 10000;
    localparam logic signed [31:0] CceHi  = 32'(One - 1);
    localparam logic signed [31:0] BceLo  = 32'(BLo);
    localparam logic signed [31:0] BceHi  = 32'(BHi);
    localparam logic [F:0]         OneF   = (F+1)'(One);

    // configuration
    loss_mode_t   mode_reg;
    logic [23:0]  ecount_reg;
    logic [15:0]  bcount_reg;
    logic [30:0]  delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MSE;
            ecount_reg <= 24'd1;
            bcount_reg <= 16'd1;
            delta_reg  <= 31'(One);
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_LOSS_MODE:     mode_reg   <= loss_mode_t'(cfg_data[1:0]);
                REG_ELEMENT_COUNT: ecount_reg <= cfg_data[23:0];
                REG_BATCH_COUNT:   bcount_reg <= cfg_data[15:0];
                REG_HUBER_DELTA:   delta_reg  <= cfg_data;
                default:           mode_reg   <= mode_reg;
            endcase
        end
    end

    logic [23:0] n_eff;
    logic [15:0] b_eff;
    assign n_eff = (ecount_reg == '0) ? 24'd1 : ecount_reg;
    assign b_eff = (bcount_reg == '0) ? 16'd1 : bcount_reg;

    assign busy = 1'b0;

    // stage 1: differences and clamps
    logic                vld_s1_reg;
    logic signed [32:0]  diff_s1_reg, diff_s1_next;
    logic signed [31:0]  t_s1_reg;
    logic [F-1:0]        pcc_s1_reg, pcc_s1_next;
    logic [F-1:0]        pcb_s1_reg, pcb_s1_next;
    logic signed [32:0]  dbce_s1_reg, dbce_s1_next;

    always_comb
    begin
        diff_s1_next = 33'(pred_value) - 33'(target_value);
        if (pred_value < 32'sd1)
            pcc_s1_next = F'(1);
        else if (pred_value > CceHi)
            pcc_s1_next = F'(CceHi);
        else
            pcc_s1_next = pred_value[F-1:0];
        if (pred_value < BceLo)
            pcb_s1_next = F'(BceLo);
        else if (pred_value > BceHi)
            pcb_s1_next = F'(BceHi);
        else
            pcb_s1_next = pred_value[F-1:0];
        dbce_s1_next = $signed({{(33-F){1'b0}}, pcb_s1_next}) - 33'(target_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s1_reg <= 1'b0;
        else
            vld_s1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        diff_s1_reg <= diff_s1_next;
        t_s1_reg    <= target_value;
        pcc_s1_reg  <= pcc_s1_next;
        pcb_s1_reg  <= pcb_s1_next;
        dbce_s1_reg <= dbce_s1_next;
    end

    // stage 2: numerator, sign, small products
    logic                vld_s2_reg;
    logic [NW-1:0]       num_s2_reg, num_s2_next;
    logic                neg_s2_reg, neg_s2_next;
    logic [2*F-1:0]      var_s2_reg;
    logic [F+15:0]       cb_s2_reg;
    logic [32:0]         mdiff, mt, mdbce;

    assign mdiff = diff_s1_reg[32] ? 33'(-diff_s1_reg) : 33'(diff_s1_reg);
    assign mt    = t_s1_reg[31] ? (33'd0 - 33'(t_s1_reg)) : 33'(t_s1_reg);
    assign mdbce = dbce_s1_reg[32] ? 33'(-dbce_s1_reg) : 33'(dbce_s1_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_MSE:
            begin
                num_s2_next = NW'(mdiff) << 1;
                neg_s2_next = diff_s1_reg[32];
            end
            MODE_CCE:
            begin
                num_s2_next = NW'(mt) << F;
                neg_s2_next = (t_s1_reg > 32'sd0);
            end
            MODE_BCE:
            begin
                num_s2_next = NW'(mdbce) << (2*F);
                neg_s2_next = dbce_s1_reg[32];
            end
            default:
            begin
                num_s2_next = (mdiff <= 33'(delta_reg)) ? NW'(mdiff) : NW'(delta_reg);
                neg_s2_next = diff_s1_reg[32];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s2_reg <= 1'b0;
        else
            vld_s2_reg <= vld_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        num_s2_reg <= num_s2_next;
        neg_s2_reg <= neg_s2_next;
        var_s2_reg <= (2*F)'(pcb_s1_reg) * (2*F)'(F'(OneF - (F+1)'(pcb_s1_reg)));
        cb_s2_reg  <= (F+16)'(pcc_s1_reg) * (F+16)'(b_eff);
    end

    // stage 3: variance times count, split in two halves
    logic                vld_s3_reg;
    logic [NW-1:0]       num_s3_reg;
    logic                neg_s3_reg;
    logic [2*F+11:0]     dlo_s3_reg, dhi_s3_reg;
    logic [F+15:0]       cb_s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s3_reg <= 1'b0;
        else
            vld_s3_reg <= vld_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        num_s3_reg <= num_s2_reg;
        neg_s3_reg <= neg_s2_reg;
        cb_s3_reg  <= cb_s2_reg;
        dlo_s3_reg <= (2*F+12)'(var_s2_reg) * (2*F+12)'(n_eff[11:0]);
        dhi_s3_reg <= (2*F+12)'(var_s2_reg) * (2*F+12)'(n_eff[23:12]);
    end

    // divider pipeline, index 0 is loaded from the front end
    logic          dv_vld_reg [NW+1];
    logic [DW-1:0] dv_rem_reg [NW+1];
    logic [NW-1:0] dv_nq_reg  [NW+1];
    logic [DW-1:0] dv_den_reg [NW+1];
    logic          dv_neg_reg [NW+1];
    logic [DW-1:0] den_next;

    always_comb
    begin
        case (mode_reg)
            MODE_CCE: den_next = DW'(cb_s3_reg);
            MODE_BCE: den_next = DW'(dlo_s3_reg) + (DW'(dhi_s3_reg) << 12);
            default:  den_next = DW'(n_eff);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else
            dv_vld_reg[0] <= vld_s3_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= '0;
        dv_nq_reg[0]  <= num_s3_reg;
        dv_den_reg[0] <= den_next;
        dv_neg_reg[0] <= neg_s3_reg;
    end

    for (genvar k = 1; k <= NW; k++)
    begin : g_div
        logic [DW:0]   shifted;
        logic          ge;
        logic [DW:0]   diffw;

        assign shifted = {dv_rem_reg[k-1], dv_nq_reg[k-1][NW-1]};
        assign ge      = shifted >= {1'b0, dv_den_reg[k-1]};
        assign diffw   = shifted - {1'b0, dv_den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k] <= 1'b0;
            else
                dv_vld_reg[k] <= dv_vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k] <= ge ? diffw[DW-1:0] : shifted[DW-1:0];
            dv_nq_reg[k]  <= {dv_nq_reg[k-1][NW-2:0], ge};
            dv_den_reg[k] <= dv_den_reg[k-1];
            dv_neg_reg[k] <= dv_neg_reg[k-1];
        end
    end

    // sign and saturation
    logic          done_reg;
    logic [31:0]   grad_reg, grad_next;
    logic          sat_reg, sat_next;
    logic [NW-1:0] quot;
    logic [31:0]   limit, mag;

    assign quot  = dv_nq_reg[NW];
    assign limit = dv_neg_reg[NW] ? 32'h8000_0000 : 32'h7FFF_FFFF;

    always_comb
    begin
        sat_next  = (quot[NW-1:32] != '0) || (quot[31:0] > limit);
        mag       = sat_next ? limit : quot[31:0];
        grad_next = dv_neg_reg[NW] ? (32'd0 - mag) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld_reg[NW];
    end

    always_ff @(posedge clk)
    begin
        grad_reg <= grad_next;
        sat_reg  <= sat_next;
    end

    assign done       = done_reg;
    assign grad_value = grad_reg;
    assign saturated  = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transfer did not complete at the fixed latency");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (grad_value == 32'sh7FFF_FFFF || grad_value == 32'sh8000_0000))
        else $error("saturated result not at a limit");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[1] |-> (dv_den_reg[1] != '0))
        else $error("zero divisor entered the divider");

endmodule

>>> verif/lgu_checker.sv
`timescale 1ns / 100ps
// lgu_checker: predicts each gradient element of the loss gradient unit and checks done results.
// Depends on lgu_pkg; instantiated beside the block by tb_loss_gradient_unit_top.
module lgu_checker
    import lgu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic signed [31:0]    pred_value,
    input  logic signed [31:0]    target_value,
    input  logic                  cfg_write,
    input  logic [CfgIndexW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0]   cfg_data,
    input  logic                  done,
    input  logic signed [31:0]    grad_value,
    input  logic                  saturated,
    output int                    fail_count,
    output int                    pending
);

    localparam longint OneQ = 64'd1 << DefFracBits;
    localparam longint BceLo = (OneQ + 9999) / 10000;
    localparam longint BceHi = OneQ * 9999 / 10000;

    typedef struct packed {
        logic [31:0] grad;
        logic        sat;
    } grad_item_t;

    loss_mode_t  mode_q;
    logic [23:0] elem_q;
    logic [15:0] batch_q;
    logic [30:0] delta_q;
    grad_item_t  grad_queue[$];

    assign pending = grad_queue.size();

    function automatic grad_item_t divide_sat(bit neg, logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        logic [31:0]  lim;
        grad_item_t   r;
        q = num / den;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (q > {96'd0, lim})
        begin
            r.grad = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end
        else
        begin
            r.grad = neg ? -q[31:0] : q[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic grad_item_t predict_gradient(longint p, longint t);
        longint       diff;
        longint       pc;
        longint       d;
        logic [127:0] n;
        logic [127:0] b;
        logic [127:0] m;
        diff = p - t;
        n = (elem_q == 0) ? 128'd1 : 128'(elem_q);
        b = (batch_q == 0) ? 128'd1 : 128'(batch_q);
        m = 128'(diff < 0 ? -diff : diff);
        case (mode_q)
            MODE_MSE: return divide_sat(diff < 0, m * 2, n);
            MODE_CCE:
            begin
                pc = p < 1 ? 1 : (p > OneQ - 1 ? OneQ - 1 : p);
                return divide_sat(t > 0, 128'(t < 0 ? -t : t) * OneQ, 128'(pc) * b);
            end
            MODE_BCE:
            begin
                pc = p < BceLo ? BceLo : (p > BceHi ? BceHi : p);
                d = pc - t;
                return divide_sat(d < 0, 128'(d < 0 ? -d : d) * OneQ * OneQ,
                                  128'(pc) * 128'(OneQ - pc) * n);
            end
            default:
            begin
                if (m <= 128'(delta_q))
                    return divide_sat(diff < 0, m, n);
                return divide_sat(diff < 0, 128'(delta_q), n);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grad_item_t e;
        if (!rst_n)
        begin
            mode_q = MODE_MSE;
            elem_q = 24'd1;
            batch_q = 16'd1;
            delta_q = 31'd65536;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (grad_queue.size() == 0)
                    report_mismatch("unexpected transfer", grad_value, 32'd0);
                else
                begin
                    e = grad_queue.pop_front();
                    if (grad_value !== e.grad)
                        report_mismatch("grad_value", grad_value, e.grad);
                    if (saturated !== e.sat)
                        report_mismatch("saturated", 32'(saturated), 32'(e.sat));
                end
            end
            if (start && !busy)
                grad_queue.push_back(predict_gradient(longint'(pred_value),
                                                      longint'(target_value)));
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_LOSS_MODE:     mode_q = loss_mode_t'(cfg_data[1:0]);
                    REG_ELEMENT_COUNT: elem_q = cfg_data[23:0];
                    REG_BATCH_COUNT:   batch_q = cfg_data[15:0];
                    default:           delta_q = cfg_data;
                endcase
            end
        end
    end

endmodule

>>> verif/tb_loss_gradient_unit_top.sv
`timescale 1ns / 100ps
// tb_loss_gradient_unit_top: drives directed and random transfers through each loss mode.
// Depends on lgu_pkg, loss_gradient_unit_top and lgu_checker.
module tb_loss_gradient_unit_top;
    import lgu_pkg::*;

    localparam int Latency = 2 * DefFracBits + 38;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   pred_value;
    logic signed [31:0]   target_value;
    logic                 cfg_write;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;
    logic                 done;
    logic signed [31:0]   grad_value;
    logic                 saturated;
    int                   fail_count;
    int                   pending;

    loss_gradient_unit_top uut (.*);
    lgu_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, logic [30:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    // one transfer; optional gap before it
    task automatic send_item(logic [31:0] p, logic [31:0] t, bit gaps);
        int g;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        pred_value <= p;
        target_value <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value(loss_mode_t m);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 65536);
            2: return 32'($urandom_range(0, 400000)) - 32'd200000;
            3: return (m == MODE_CCE) ? 32'($urandom_range(0, 20)) : $urandom & 32'h0003_FFFF;
            4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 2))};
            default: return 32'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [23:0] rand_elem();
        case ($urandom_range(0, 4))
            0: return 24'd1;
            1: return 24'hFF_FFFF;
            2: return 24'd0;
            default: return 24'($urandom_range(1, 1 << $urandom_range(1, 24)));
        endcase
    endfunction

    initial
    begin
        logic [31:0] edges[8];
        loss_mode_t  m;
        int          i;
        int          j;
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h0000_FFFF, 32'h0000_0007};
        rst_n = 1'b0;
        start = 1'b0;
        pred_value = '0;
        target_value = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each mode at reset counts, field extremes
        for (i = 0; i < 4; i++)
        begin
            write_reg(REG_LOSS_MODE, 31'(i));
            for (j = 0; j < 6; j++)
                send_item(edges[j], edges[(j + 3 + i) % 8], 1'b0);
            drain();
        end
        write_reg(REG_HUBER_DELTA, 31'd0);
        send_item(32'd5, 32'd0, 1'b0);
        send_item(32'd5, 32'd5, 1'b0);
        drain();
        write_reg(REG_ELEMENT_COUNT, 31'd0);
        write_reg(REG_BATCH_COUNT, 31'd0);
        write_reg(REG_HUBER_DELTA, 31'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        drain();

        for (i = 0; i < 37; i++)
        begin
            m = loss_mode_t'(i % 4);
            write_reg(REG_LOSS_MODE, 31'(m));
            write_reg(REG_ELEMENT_COUNT, 31'(rand_elem()));
            write_reg(REG_BATCH_COUNT, (i % 5 == 0) ? 31'hFFFF : 31'($urandom_range(0, 65535)));
            write_reg(REG_HUBER_DELTA, (i % 6 == 0) ? 31'h7FFF_FFFF : 31'($urandom) >> $urandom_range(0, 30));
            for (j = 0; j < 50; j++)
                send_item(rand_value(m), rand_value(m), (i % 3) != 0);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/lgu_pkg.sv
design/loss_gradient_unit_top.sv
verif/lgu_checker.sv
verif/tb_loss_gradient_unit_top.sv
